// File: rtl/core/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

  localparam int VAL_W       = 32;
  localparam int Q_FRAC      = 16;

  // iteration counts of the shared unit
  localparam int MUL_STEPS   = 32;
  localparam int DIV_STEPS   = 48;
  localparam int REM_STEPS   = 16;
  localparam int CNT_W       = 6;

  typedef enum logic [2:0] {
    FN_OPERAND = 3'd0,
    FN_ADD     = 3'd1,
    FN_SUB     = 3'd2,
    FN_MUL     = 3'd3,
    FN_DIV     = 3'd4,
    FN_REM     = 3'd5
  } func_e;

  typedef struct packed {
    logic             start;
    func_e            op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic             div_zero;
    logic [VAL_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: rtl/core/pse_stack_ram.sv
// ----------------------------------------------------------------------------
// pse_stack_ram
// Value stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pse_stack_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pse_pkg::STK_AW-1:0] waddr_i,
  input  logic [pse_pkg::VAL_W-1:0]  wdata_i,
  input  logic [pse_pkg::STK_AW-1:0] raddr_i,
  output logic [pse_pkg::VAL_W-1:0]  rdata_o
);

  logic [pse_pkg::VAL_W-1:0] mem [pse_pkg::STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu
// Shared Q16.16 arithmetic unit: one 34-bit adder serves add, subtract,
// shift-add multiply and restoring divide / remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::alu_req_t req_i,
  output pse_pkg::alu_rsp_t rsp_o
);

  typedef enum logic [5:0] {
    A_IDLE   = 6'b000001,
    A_ADDSUB = 6'b000010,
    A_MUL    = 6'b000100,
    A_DIV    = 6'b001000,
    A_POST1  = 6'b010000,
    A_POST2  = 6'b100000
  } alu_state_e;

  alu_state_e state_q, state_d;
  pse_pkg::func_e op_q, op_d;

  logic [31:0]        a_q, a_d, b_q, b_d;
  logic [31:0]        mcand_q, mcand_d, mplier_q, mplier_d;
  logic [63:0]        acc_q, acc_d;
  logic [47:0]        dvd_q, dvd_d;
  logic [31:0]        dvs_q, dvs_d, rem_q, rem_d;
  logic               neg_q, neg_d;
  logic [pse_pkg::CNT_W-1:0] cnt_q, cnt_d, lim_q, lim_d;
  logic signed [63:0] p_q, p_d;
  logic               done_q, done_d, dz_q, dz_d;
  logic [31:0]        res_q, res_d;

  logic [33:0]        add_x, add_y, sum;
  logic               add_sub;
  logic [31:0]        abs_a, abs_b;
  logic [63:0]        mag;
  logic signed [63:0] rnd;
  logic               qbit;

  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) r = v[31:0];
    else if (v[33]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  assign abs_a = req_i.a[31] ? (~req_i.a + 32'd1) : req_i.a;
  assign abs_b = req_i.b[31] ? (~req_i.b + 32'd1) : req_i.b;

  // shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      A_ADDSUB: begin
        add_x   = {{2{a_q[31]}}, a_q};
        add_y   = {{2{b_q[31]}}, b_q};
        add_sub = (op_q == pse_pkg::FN_SUB);
      end
      A_MUL: begin
        add_x = {2'b00, acc_q[63:32]};
        add_y = mplier_q[0] ? {2'b00, mcand_q} : '0;
      end
      A_DIV: begin
        add_x   = {1'b0, rem_q, dvd_q[47]};
        add_y   = {2'b00, dvs_q};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = add_x + (add_sub ? ~add_y : add_y) + {33'd0, add_sub};

  always_comb begin
    case (op_q)
      pse_pkg::FN_MUL: mag = acc_q;
      pse_pkg::FN_DIV: mag = {16'd0, dvd_q};
      default:         mag = {32'd0, rem_q[15:0], 16'd0};
    endcase
  end

  // round half up, floor shift
  assign rnd  = (p_q + 64'sd32768) >>> pse_pkg::Q_FRAC;
  assign qbit = ~sum[33];

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    cnt_d    = cnt_q;
    lim_d    = lim_q;
    p_d      = p_q;
    done_d   = 1'b0;
    dz_d     = dz_q;
    res_d    = res_q;

    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d     = req_i.op;
          a_d      = req_i.a;
          b_d      = req_i.b;
          dz_d     = 1'b0;
          cnt_d    = '0;
          rem_d    = '0;
          acc_d    = '0;
          mcand_d  = abs_a;
          mplier_d = abs_b;
          neg_d    = req_i.a[31] ^ req_i.b[31];
          case (req_i.op)
            pse_pkg::FN_ADD, pse_pkg::FN_SUB: state_d = A_ADDSUB;
            pse_pkg::FN_MUL:                  state_d = A_MUL;
            pse_pkg::FN_DIV: begin
              if (req_i.b == '0) begin
                dz_d   = 1'b1;
                res_d  = '0;
                done_d = 1'b1;
              end else begin
                dvd_d   = {abs_a, 16'd0};
                dvs_d   = abs_b;
                lim_d   = pse_pkg::CNT_W'(pse_pkg::DIV_STEPS - 1);
                state_d = A_DIV;
              end
            end
            pse_pkg::FN_REM: begin
              // integer parts only; remainder takes the dividend's sign
              if (abs_b[31:16] == '0) begin
                dz_d   = 1'b1;
                res_d  = '0;
                done_d = 1'b1;
              end else begin
                dvd_d   = {abs_a[31:16], 32'd0};
                dvs_d   = {16'd0, abs_b[31:16]};
                neg_d   = req_i.a[31];
                lim_d   = pse_pkg::CNT_W'(pse_pkg::REM_STEPS - 1);
                state_d = A_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      A_ADDSUB: begin
        res_d   = sat34(sum);
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_MUL: begin
        acc_d    = {sum[32:0], acc_q[31:1]};
        mplier_d = {1'b0, mplier_q[31:1]};
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == pse_pkg::CNT_W'(pse_pkg::MUL_STEPS - 1)) state_d = A_POST1;
      end
      A_DIV: begin
        rem_d = qbit ? sum[31:0] : {rem_q[30:0], dvd_q[47]};
        dvd_d = {dvd_q[46:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lim_q) state_d = A_POST1;
      end
      A_POST1: begin
        p_d     = neg_q ? -$signed(mag) : $signed(mag);
        state_d = A_POST2;
      end
      A_POST2: begin
        res_d   = sat64((op_q == pse_pkg::FN_MUL) ? rnd : p_q);
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    lim_q    <= lim_d;
    p_q      <= p_d;
    dz_q     <= dz_d;
    res_q    <= res_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.result   = res_q;

endmodule

// File: rtl/core/postfix_stack_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix token evaluator over a Q16.16 value stack with one shared ALU.
// ----------------------------------------------------------------------------
// Tokens arrive one beat at a time on the slave stream; tuser carries the
// token kind and tdata the unsigned operand. The beat with tlast set closes
// the expression and one result beat follows (stack top, tuser = error).
// Operators run on the bit-serial shared ALU, and the slave side is not ready
// again until the result is written back; operands, unknown kinds and stack
// underflows take no ALU pass. A closing beat passes through the finishing
// state, which waits while the previous result still waits on the master
// side. The top of stack sits in a register, so each operator needs a single
// read of the stack memory.
module postfix_stack_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [14:0] operand_value, [15] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] func
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_value
  output logic        m_axis_tuser_o,   // [0] error_flag
  output logic        m_axis_tlast_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OP   = 4'b0010,
    S_ALU  = 4'b0100,
    S_FIN  = 4'b1000
  } seq_state_e;

  seq_state_e state_q, state_d;

  logic [pse_pkg::STK_CW-1:0] count_q, count_d;
  logic                       err_q, err_d;
  logic                       last_q, last_d;
  pse_pkg::func_e             op_q, op_d;
  logic [pse_pkg::VAL_W-1:0]  top_q, top_d;

  logic                       m_valid_q, m_valid_d;
  logic [31:0]                m_data_q, m_data_d;
  logic                       m_err_q, m_err_d;

  logic                       we;
  logic [pse_pkg::STK_AW-1:0] waddr, raddr;
  logic [pse_pkg::VAL_W-1:0]  wdata, rdata;
  logic [pse_pkg::STK_CW-1:0] below_top;

  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;

  logic s_beat, out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign below_top       = count_q - pse_pkg::STK_CW'(2);
  assign raddr           = below_top[pse_pkg::STK_AW-1:0];

  pse_stack_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    err_d     = err_q;
    last_d    = last_q;
    op_d      = op_q;
    top_d     = top_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_err_d   = m_err_q;
    we        = 1'b0;
    waddr     = count_q[pse_pkg::STK_AW-1:0];
    wdata     = {1'b0, s_axis_tdata_i[14:0], {pse_pkg::Q_FRAC{1'b0}}};
    alu_req   = '{start: 1'b0, op: op_q, a: rdata, b: top_q};

    unique case (state_q)
      S_IDLE: begin
        if (s_beat) begin
          last_d  = s_axis_tlast_i;
          state_d = s_axis_tlast_i ? S_FIN : S_IDLE;
          case (s_axis_tuser_i) inside
            pse_pkg::FN_OPERAND: begin
              if (count_q < pse_pkg::STK_CW'(pse_pkg::STACK_DEPTH)) begin
                we      = 1'b1;
                top_d   = wdata;
                count_d = count_q + 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
            pse_pkg::FN_ADD, pse_pkg::FN_SUB, pse_pkg::FN_MUL,
            pse_pkg::FN_DIV, pse_pkg::FN_REM: begin
              if (count_q < pse_pkg::STK_CW'(2)) begin
                err_d = 1'b1;
              end else begin
                op_d    = pse_pkg::func_e'(s_axis_tuser_i);
                state_d = S_OP;
              end
            end
            default: ;
          endcase
        end
      end
      S_OP: begin
        // rdata now holds the entry below the top
        alu_req.start = 1'b1;
        state_d       = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          we      = 1'b1;
          waddr   = raddr;
          wdata   = alu_rsp.result;
          top_d   = alu_rsp.result;
          count_d = count_q - 1'b1;
          err_d   = err_q | alu_rsp.div_zero;
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = (count_q == '0) ? '0 : top_q;
          m_err_d   = err_q | (count_q == '0);
          count_d   = '0;
          err_d     = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      err_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      err_q     <= err_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    op_q     <= op_d;
    top_q    <= top_d;
    m_data_q <= m_data_d;
    m_err_q  <= m_err_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_err_q;
  assign m_axis_tlast_o  = 1'b1;

endmodule

// File: rtl/core/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks of the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic [2:0]  s_axis_tuser_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic s_beat;
  assign s_beat = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // the slave side is not ready straight after a closing beat
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("ready straight after closing beat");

  // plain pushes go back to back
  a_push_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && !s_axis_tlast_i && (s_axis_tuser_i == pse_pkg::FN_OPERAND)
      |=> s_axis_tready_o)
    else $error("not ready after operand beat");

  // every result beat is marked last
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> m_axis_tlast_o && !s_axis_tready_o || m_axis_tlast_o)
    else $error("result beat without tlast");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (.*);
